// File: src/ltnm_pkg.sv
// Shared types and constants of the lexer token NFA matcher.
package ltnm_pkg;

  localparam int NUM_MATCHERS = 9;
  localparam int STATE_W      = 40;
  localparam int CFG_W        = 9;
  localparam int QUEUE_DEPTH  = 2;

  // Start sets of all nine matchers, packed from bit 0 in matcher order
  // with vector widths 5, 3, 3, 7, 7, 3, 2, 5, 5.
  localparam logic [STATE_W-1:0] START_ALL =
      (40'd1 <<  0) | (40'd3 <<  5) | (40'd3 <<  8) | (40'd3 << 11) |
      (40'd3 << 18) | (40'd3 << 25) | (40'd1 << 28) | (40'd1 << 30) |
      (40'd1 << 35);

  // Character classes of one byte, with the restart flag carried along.
  typedef struct packed {
    logic first;
    logic dec;
    logic hex;
    logic pm;
    logic dd;
    logic dot;
    logic quote;
    logic slash;
    logic cr;
    logic lf;
    logic ff;
    logic dollar;
    logic hash;
    logic special;
  } class_t;

  // Per matcher: any state active, and accepting state active.
  function automatic logic [NUM_MATCHERS-1:0] ok_of(input logic [STATE_W-1:0] s);
    ok_of = {|s[39:35], |s[34:30], |s[29:28], |s[27:25], |s[24:18],
             |s[17:11], |s[10:8], |s[7:5], |s[4:0]};
  endfunction

  function automatic logic [NUM_MATCHERS-1:0] acc_of(input logic [STATE_W-1:0] s);
    acc_of = {s[39], s[34], s[29], s[27], s[24], s[17], s[10], s[7], s[4]};
  endfunction

endpackage

// File: src/ltnm_front.sv
// Front end: takes one byte per transaction and sorts it into character classes.
module ltnm_front (
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_ch,
  input  logic                in_first,
  input  logic                q_full,
  output logic                q_push,
  output ltnm_pkg::class_t    q_data
);

  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_CARET  = 8'h5e;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_VT     = 8'h0b;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_D_LO   = 8'h64;
  localparam logic [7:0] CH_D_UP   = 8'h44;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_A_LO   = 8'h61;
  localparam logic [7:0] CH_F_LO   = 8'h66;
  localparam logic [7:0] CH_A_UP   = 8'h41;
  localparam logic [7:0] CH_F_UP   = 8'h46;

  logic special;

  always_comb begin
    unique case (in_ch) inside
      CH_DQUOTE, CH_QUOTE, CH_COLON, CH_EQ, CH_COMMA, CH_DOT, CH_AT, CH_CARET,
      CH_HASH, CH_PLUS, CH_MINUS, CH_SPACE, CH_TAB, CH_DOLLAR, CH_LBRACE,
      CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_LT, CH_GT,
      CH_CR, CH_LF, CH_VT, CH_FF: special = 1'b1;
      default: special = 1'b0;
    endcase
  end

  always_comb begin
    q_data.first   = in_first;
    q_data.dec     = (in_ch >= CH_0) && (in_ch <= CH_9);
    q_data.hex     = ((in_ch >= CH_0) && (in_ch <= CH_9)) ||
                     ((in_ch >= CH_A_LO) && (in_ch <= CH_F_LO)) ||
                     ((in_ch >= CH_A_UP) && (in_ch <= CH_F_UP));
    q_data.pm      = (in_ch == CH_PLUS) || (in_ch == CH_MINUS);
    q_data.dd      = (in_ch == CH_D_LO) || (in_ch == CH_D_UP);
    q_data.dot     = (in_ch == CH_DOT);
    q_data.quote   = (in_ch == CH_QUOTE);
    q_data.slash   = (in_ch == CH_SLASH);
    q_data.cr      = (in_ch == CH_CR);
    q_data.lf      = (in_ch == CH_LF);
    q_data.ff      = (in_ch == CH_FF);
    q_data.dollar  = (in_ch == CH_DOLLAR);
    q_data.hash    = (in_ch == CH_HASH);
    q_data.special = special;
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

endmodule

// File: src/ltnm_queue.sv
// Short queue of classified bytes between the front end and the NFA back end.
module ltnm_queue #(
  parameter int DEPTH = ltnm_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ltnm_pkg::class_t wr_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output ltnm_pkg::class_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  ltnm_pkg::class_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [AW-1:0] incr(input logic [AW-1:0] p);
    if (p == AW'(DEPTH - 1)) incr = '0;
    else incr = p + AW'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? incr(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? incr(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) count_nxt = count_r + CW'(1);
    else if (!push && pop) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data   = mem[rd_ptr_r];
  assign full      = (count_r == DEPTH_C);
  assign not_empty = (count_r != '0);

  property p_count_bound;
    @(posedge clk) disable iff (!rst_n) count_r <= DEPTH_C;
  endproperty
  a_count_bound: assert property (p_count_bound) else $error("queue count overflow");

  property p_no_push_when_full;
    @(posedge clk) disable iff (!rst_n) push |-> !full;
  endproperty
  a_no_push_when_full: assert property (p_no_push_when_full)
    else $error("push into a full queue");

  property p_no_pop_when_empty;
    @(posedge clk) disable iff (!rst_n) pop |-> not_empty;
  endproperty
  a_no_pop_when_empty: assert property (p_no_pop_when_empty)
    else $error("pop from an empty queue");

endmodule

// File: src/ltnm_back.sv
// Back end: steps the nine state vectors and holds the result for the receiver.
module ltnm_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  q_not_empty,
  input  ltnm_pkg::class_t                      q_data,
  output logic                                  q_pop,
  input  logic                                  cfg_we,
  input  logic [ltnm_pkg::CFG_W-1:0]            cfg_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ltnm_pkg::NUM_MATCHERS-1:0]     out_ok_mask,
  output logic [ltnm_pkg::NUM_MATCHERS-1:0]     out_accept_mask,
  output logic                                  out_any_ok,
  output logic                                  out_any_accept
);

  logic [ltnm_pkg::STATE_W-1:0]      active_r, active_nxt, cur;
  logic [ltnm_pkg::CFG_W-1:0]        enable_r;
  logic                              out_valid_r, out_valid_nxt;
  logic [ltnm_pkg::NUM_MATCHERS-1:0] ok_r, acc_r, ok_n, acc_n;
  logic                              any_ok_r, any_acc_r;
  logic [4:0] s0, n0;
  logic [2:0] s1, n1, s2, n2, s5, n5;
  logic [6:0] s3, n3, s4, n4;
  logic [1:0] s6, n6;
  logic [4:0] s7, n7, s8, n8;
  logic       inner;
  ltnm_pkg::class_t c;

  assign c   = q_data;
  assign cur = c.first ? ltnm_pkg::START_ALL : active_r;
  assign {s8, s7, s6, s5, s4, s3, s2, s1, s0} = cur;

  always_comb begin
    inner = !(c.quote || c.lf || c.cr || c.ff);

    // Line comment.
    n0[0] = 1'b0;
    n0[1] = s0[0] && c.slash;
    n0[2] = (s0[1] && c.slash) || (s0[2] && !c.cr && !c.lf);
    n0[3] = s0[2] && c.lf;
    n0[4] = (s0[2] && (c.lf || c.cr)) || (s0[3] && c.lf);

    // Integer and integer date.
    n1[0] = 1'b0;
    n1[1] = (s1[0] && c.pm) || (s1[1] && c.dec);
    n1[2] = s1[1] && c.dec;
    n2[0] = 1'b0;
    n2[1] = (s2[0] && c.pm) || (s2[1] && c.dec);
    n2[2] = s2[1] && c.dd;

    // Float.
    n3[0] = 1'b0;
    n3[1] = s3[0] && c.pm;
    n3[2] = (s3[1] || s3[2]) && c.dec;
    n3[3] = (s3[2] && c.dot) || (s3[3] && c.dec);
    n3[4] = s3[1] && c.dot;
    n3[5] = (s3[4] || s3[5]) && c.dec;
    n3[6] = (s3[2] && c.dot) || ((s3[3] || s3[4] || s3[5]) && c.dec);

    // Float date.
    n4[0] = 1'b0;
    n4[1] = s4[0] && c.pm;
    n4[2] = (s4[1] || s4[2]) && c.dec;
    n4[3] = (s4[2] && c.dot) || (s4[3] && c.dec);
    n4[4] = s4[1] && c.dot;
    n4[5] = (s4[4] || s4[5]) && c.dec;
    n4[6] = (s4[3] || s4[5]) && c.dd;

    // Hex.
    n5[0] = 1'b0;
    n5[1] = (s5[0] && c.dollar) || (s5[1] && c.hex);
    n5[2] = s5[1] && c.hex;

    // Bare identifier: the start state loops on itself.
    n6[0] = s6[0] && !c.special;
    n6[1] = s6[0] && !c.special;

    // Quoted string; a doubled quote returns to the body.
    n7[0] = 1'b0;
    n7[1] = (s7[0] && c.quote) || ((s7[1] || s7[3]) && inner);
    n7[2] = s7[1] && c.quote;
    n7[3] = s7[2] && c.quote;
    n7[4] = (s7[1] || s7[3]) && c.quote;

    // Char code.
    n8[0] = 1'b0;
    n8[1] = s8[0] && c.hash;
    n8[2] = (s8[1] && c.dollar) || (s8[2] && c.hex);
    n8[3] = (s8[0] && c.hash) || (s8[3] && c.dec);
    n8[4] = (s8[2] && c.hex) || (s8[3] && c.dec);
  end

  assign ok_n  = ltnm_pkg::ok_of({n8, n7, n6, n5, n4, n3, n2, n1, n0});
  assign acc_n = ltnm_pkg::acc_of({n8, n7, n6, n5, n4, n3, n2, n1, n0});

  assign q_pop = q_not_empty && (!out_valid_r || out_ready);

  always_comb begin
    active_nxt    = q_pop ? {n8, n7, n6, n5, n4, n3, n2, n1, n0} : active_r;
    out_valid_nxt = q_pop || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= ltnm_pkg::START_ALL;
      enable_r    <= '1;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        enable_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ok_r      <= ok_n;
      acc_r     <= acc_n;
      any_ok_r  <= |(ok_n & enable_r);
      any_acc_r <= |(acc_n & enable_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok_mask     = ok_r;
  assign out_accept_mask = acc_r;
  assign out_any_ok      = any_ok_r;
  assign out_any_accept  = any_acc_r;

  property p_pop_gives_result;
    @(posedge clk) disable iff (!rst_n) q_pop |=> out_valid_r;
  endproperty
  a_pop_gives_result: assert property (p_pop_gives_result)
    else $error("popped byte produced no result");

  property p_accept_implies_ok;
    @(posedge clk) disable iff (!rst_n) out_valid_r |-> ((acc_r & ~ok_r) == '0);
  endproperty
  a_accept_implies_ok: assert property (p_accept_implies_ok)
    else $error("accept bit set on a dead matcher");

  property p_ok_tracks_state;
    @(posedge clk) disable iff (!rst_n)
      out_valid_r |-> (ok_r == ltnm_pkg::ok_of(active_r));
  endproperty
  a_ok_tracks_state: assert property (p_ok_tracks_state)
    else $error("reported ok mask differs from the held state vectors");

endmodule

// File: src/lexer_token_nfa_matcher_unit.sv
// Lexer token matcher: nine bit-parallel NFAs stepped by one byte per transaction.
//
// Input channel (in_valid/in_ready): one byte in_ch of a candidate token and
// in_first, which restarts every matcher at its start set before that byte.
// Result channel (out_valid/out_ready): per byte, out_ok_mask and
// out_accept_mask with one bit per matcher, plus their OR over the matchers
// enabled in the configuration register.
// Configuration channel (cfg_valid/cfg_ready): writes the 9-bit matcher
// enable; it is always ready and should only be written while no byte is
// in flight.
// An accepted byte is written into a short queue; the back end pops it, steps
// the state vectors and loads the result register, and the block sustains one
// byte per cycle while the receiver takes every result.
// When the receiver stalls, the result register holds, the queue fills, and
// in_ready drops once the queue is full.
// Reset clears the queue and the result valid flag, loads every start set and
// enables all matchers, so the first byte after reset needs no restart flag.
module lexer_token_nfa_matcher_unit #(
  parameter int QUEUE_DEPTH = ltnm_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_ch,
  input  logic                              in_first,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ltnm_pkg::NUM_MATCHERS-1:0] out_ok_mask,
  output logic [ltnm_pkg::NUM_MATCHERS-1:0] out_accept_mask,
  output logic                              out_any_ok,
  output logic                              out_any_accept,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ltnm_pkg::CFG_W-1:0]        cfg_data
);

  ltnm_pkg::class_t push_data, pop_data;
  logic push, pop, full, not_empty;

  assign cfg_ready = 1'b1;

  ltnm_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_ch    (in_ch),
    .in_first (in_first),
    .q_full   (full),
    .q_push   (push),
    .q_data   (push_data)
  );

  ltnm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_data   (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .rd_data   (pop_data)
  );

  ltnm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (not_empty),
    .q_data          (pop_data),
    .q_pop           (pop),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ok_mask     (out_ok_mask),
    .out_accept_mask (out_accept_mask),
    .out_any_ok      (out_any_ok),
    .out_any_accept  (out_any_accept)
  );

endmodule

// File: tb/tb_top.sv
// Self-checking testbench of the lexer token NFA matcher with a built-in bit-level predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASE_ITEMS  = 80;

  // Bit position of each matcher in the result masks.
  localparam int M_COMMENT = 0;
  localparam int M_INT     = 1;
  localparam int M_INTDATE = 2;
  localparam int M_FLOAT   = 3;
  localparam int M_FLTDATE = 4;
  localparam int M_HEX     = 5;
  localparam int M_IDENT   = 6;
  localparam int M_STRING  = 7;
  localparam int M_CHAR    = 8;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_VT  = 8'h0B;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;

  localparam logic [39:0] RESTART_SET =
      (40'd1 <<  0) | (40'd3 <<  5) | (40'd3 <<  8) | (40'd3 << 11) |
      (40'd3 << 18) | (40'd3 << 25) | (40'd1 << 28) | (40'd1 << 30) |
      (40'd1 << 35);

  typedef enum int {
    TK_COMMENT, TK_INT, TK_FLOAT, TK_HEX, TK_IDENT, TK_STRING, TK_CHAR
  } token_kind_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
  } byte_item_t;

  typedef struct packed {
    logic [ltnm_pkg::NUM_MATCHERS-1:0] ok;
    logic [ltnm_pkg::NUM_MATCHERS-1:0] acc;
    logic                              any_ok;
    logic                              any_acc;
  } match_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_ch = 8'h00;
  logic in_first = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ltnm_pkg::NUM_MATCHERS-1:0] out_ok_mask;
  logic [ltnm_pkg::NUM_MATCHERS-1:0] out_accept_mask;
  logic out_any_ok;
  logic out_any_accept;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ltnm_pkg::CFG_W-1:0] cfg_data = '0;

  byte_item_t    byte_q[$];
  match_result_t result_q[$];
  logic [7:0]    tok_q[$];

  logic [39:0]                nfa_state = RESTART_SET;
  logic [ltnm_pkg::CFG_W-1:0] enable_model = 9'h1FF;
  bit                         calm = 1'b0;
  int                         error_count = 0;
  int                         checked_count = 0;
  int                         random_count = 0;
  int                         directed_count = 0;
  int                         token_count = 0;
  int                         setting_count = 0;
  int                         cycle_count = 0;

  lexer_token_nfa_matcher_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_ch           (in_ch),
    .in_first        (in_first),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ok_mask     (out_ok_mask),
    .out_accept_mask (out_accept_mask),
    .out_any_ok      (out_any_ok),
    .out_any_accept  (out_any_accept),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic bit is_special(input logic [7:0] c);
    case (c)
      "\"", "'", ":", "=", ",", ".", "@", "^", "#", "+", "-", " ", "$",
      "{", "}", "(", ")", "[", "]", "<", ">",
      CH_TAB, CH_CR, CH_LF, CH_VT, CH_FF: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Advances all nine state vectors by one byte.
  function automatic logic [39:0] nfa_advance(input logic [39:0] s, input logic [7:0] c);
    logic [4:0] cm, st, cc, ncm, nst, ncc;
    logic [2:0] it, idt, hx, nit, nidt, nhx;
    logic [6:0] fl, fd, nfl, nfd;
    logic [1:0] bid, nbid;
    bit dec, hex, pm, dd, dot, q, inner;
    cm = s[4:0];  it = s[7:5];  idt = s[10:8];  fl = s[17:11]; fd = s[24:18];
    hx = s[27:25]; bid = s[29:28]; st = s[34:30]; cc = s[39:35];
    dec = (c >= "0" && c <= "9");
    hex = dec || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    pm = (c == "+" || c == "-");
    dd = (c == "d" || c == "D");
    dot = (c == ".");
    q = (c == "'");
    inner = !(q || c == CH_LF || c == CH_CR || c == CH_FF);

    ncm = '0;
    ncm[1] = cm[0] && c == "/";
    ncm[2] = (cm[1] && c == "/") || (cm[2] && c != CH_CR && c != CH_LF);
    ncm[3] = cm[2] && c == CH_LF;
    ncm[4] = (cm[2] && (c == CH_LF || c == CH_CR)) || (cm[3] && c == CH_LF);

    nit = '0;
    nit[1] = (it[0] && pm) || (it[1] && dec);
    nit[2] = it[1] && dec;

    nidt = '0;
    nidt[1] = (idt[0] && pm) || (idt[1] && dec);
    nidt[2] = idt[1] && dd;

    nfl = '0;
    nfl[1] = fl[0] && pm;
    nfl[2] = (fl[1] || fl[2]) && dec;
    nfl[3] = (fl[2] && dot) || (fl[3] && dec);
    nfl[4] = fl[1] && dot;
    nfl[5] = (fl[4] || fl[5]) && dec;
    nfl[6] = (fl[2] && dot) || ((fl[3] || fl[4] || fl[5]) && dec);

    nfd = '0;
    nfd[1] = fd[0] && pm;
    nfd[2] = (fd[1] || fd[2]) && dec;
    nfd[3] = (fd[2] && dot) || (fd[3] && dec);
    nfd[4] = fd[1] && dot;
    nfd[5] = (fd[4] || fd[5]) && dec;
    nfd[6] = (fd[3] || fd[5]) && dd;

    nhx = '0;
    nhx[1] = (hx[0] && c == "$") || (hx[1] && hex);
    nhx[2] = hx[1] && hex;

    nbid[0] = bid[0] && !is_special(c);
    nbid[1] = nbid[0];

    nst = '0;
    nst[1] = (st[0] && q) || ((st[1] || st[3]) && inner);
    nst[2] = st[1] && q;
    nst[3] = st[2] && q;
    nst[4] = (st[1] || st[3]) && q;

    ncc = '0;
    ncc[1] = cc[0] && c == "#";
    ncc[2] = (cc[1] && c == "$") || (cc[2] && hex);
    ncc[3] = (cc[0] && c == "#") || (cc[3] && dec);
    ncc[4] = (cc[2] && hex) || (cc[3] && dec);

    return {ncc, nst, nbid, nhx, nfd, nfl, nidt, nit, ncm};
  endfunction

  // Steps the predicted state with one accepted byte and queues its expected result.
  function automatic void step_matchers(input logic [7:0] c, input logic f);
    logic [39:0] nxt;
    match_result_t r;
    nxt = nfa_advance(f ? RESTART_SET : nfa_state, c);
    r.ok[M_COMMENT] = |nxt[4:0];    r.acc[M_COMMENT] = nxt[4];
    r.ok[M_INT]     = |nxt[7:5];    r.acc[M_INT]     = nxt[7];
    r.ok[M_INTDATE] = |nxt[10:8];   r.acc[M_INTDATE] = nxt[10];
    r.ok[M_FLOAT]   = |nxt[17:11];  r.acc[M_FLOAT]   = nxt[17];
    r.ok[M_FLTDATE] = |nxt[24:18];  r.acc[M_FLTDATE] = nxt[24];
    r.ok[M_HEX]     = |nxt[27:25];  r.acc[M_HEX]     = nxt[27];
    r.ok[M_IDENT]   = |nxt[29:28];  r.acc[M_IDENT]   = nxt[29];
    r.ok[M_STRING]  = |nxt[34:30];  r.acc[M_STRING]  = nxt[34];
    r.ok[M_CHAR]    = |nxt[39:35];  r.acc[M_CHAR]    = nxt[39];
    r.any_ok  = |(r.ok & enable_model);
    r.any_acc = |(r.acc & enable_model);
    nfa_state = nxt;
    result_q.push_back(r);
  endfunction

  // Driver: presents queued bytes and predicts each transaction as it is accepted.
  always @(posedge clk) begin
    bit fire, go;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) begin
        step_matchers(in_ch, in_first);
        void'(byte_q.pop_front());
      end
      if (!in_valid || fire) begin
        go = byte_q.size() != 0 && (calm || $urandom_range(99) >= 7);
        if (go) begin
          in_valid <= 1'b1;
          in_ch <= byte_q[0].ch;
          in_first <= byte_q[0].first;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compares every result transaction with the oldest prediction.
  always @(posedge clk) begin
    match_result_t got, want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_ok_mask, out_accept_mask, out_any_ok, out_any_accept};
        if (result_q.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("Unexpected result ok=%h acc=%h any_ok=%b any_acc=%b",
                     got.ok, got.acc, got.any_ok, got.any_acc);
        end else begin
          want = result_q.pop_front();
          if (got.ok !== want.ok || got.acc !== want.acc ||
              got.any_ok !== want.any_ok || got.any_acc !== want.any_acc) begin
            error_count++;
            if (error_count <= 10)
              $display("Mismatch at result %0d: ok %h/%h acc %h/%h any_ok %b/%b any_acc %b/%b",
                       checked_count, want.ok, got.ok, want.acc, got.acc,
                       want.any_ok, got.any_ok, want.any_acc, got.any_acc);
          end
        end
        checked_count++;
      end
      out_ready <= calm || $urandom_range(99) >= 7;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic void add_item(input logic [7:0] c, input logic f);
    byte_item_t it;
    it.ch = c;
    it.first = f;
    byte_q.push_back(it);
  endfunction

  function automatic logic [7:0] pick_from(input string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  function automatic logic [7:0] rand_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (is_special(c));
    return c;
  endfunction

  function automatic logic [7:0] rand_line();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (c == CH_CR || c == CH_LF);
    return c;
  endfunction

  function automatic logic [7:0] rand_inner();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == "'" || c == CH_LF || c == CH_CR || c == CH_FF);
    return c;
  endfunction

  // Builds one token of the given kind, with random content, in tok_q.
  function automatic void build_token(input token_kind_t kind);
    int lead, tail;
    tok_q.delete();
    case (kind)
      TK_COMMENT: begin
        tok_q.push_back("/");
        tok_q.push_back("/");
        repeat ($urandom_range(5)) tok_q.push_back(rand_line());
        case ($urandom_range(3))
          0: tok_q.push_back(CH_LF);
          1: tok_q.push_back(CH_CR);
          2: begin
            tok_q.push_back(CH_CR);
            tok_q.push_back(CH_LF);
          end
          default: ;
        endcase
      end
      TK_INT: begin
        if ($urandom_range(1)) tok_q.push_back(pick_from("+-"));
        repeat ($urandom_range(1, 6)) tok_q.push_back(pick_from("0123456789"));
        if ($urandom_range(1)) tok_q.push_back(pick_from("dD"));
      end
      TK_FLOAT: begin
        if ($urandom_range(1)) tok_q.push_back(pick_from("+-"));
        lead = $urandom_range(3);
        tail = $urandom_range(lead == 0 ? 1 : 0, 3);
        repeat (lead) tok_q.push_back(pick_from("0123456789"));
        tok_q.push_back(".");
        repeat (tail) tok_q.push_back(pick_from("0123456789"));
        if ($urandom_range(1)) tok_q.push_back(pick_from("dD"));
      end
      TK_HEX: begin
        if ($urandom_range(3) != 0) tok_q.push_back("$");
        repeat ($urandom_range(1, 6)) tok_q.push_back(pick_from("0123456789abcdefABCDEF"));
      end
      TK_IDENT: begin
        repeat ($urandom_range(1, 8)) tok_q.push_back(rand_plain());
      end
      TK_STRING: begin
        tok_q.push_back("'");
        repeat ($urandom_range(5)) begin
          if ($urandom_range(3) == 0) begin
            tok_q.push_back("'");
            tok_q.push_back("'");
          end else begin
            tok_q.push_back(rand_inner());
          end
        end
        if ($urandom_range(7) != 0) tok_q.push_back("'");
      end
      default: begin
        tok_q.push_back("#");
        if ($urandom_range(1)) begin
          tok_q.push_back("$");
          repeat ($urandom_range(1, 4)) tok_q.push_back(pick_from("0123456789abcdefABCDEF"));
        end else begin
          repeat ($urandom_range(1, 4)) tok_q.push_back(pick_from("0123456789"));
        end
      end
    endcase
  endfunction

  function automatic void add_string(input string s);
    foreach (s[i]) add_item(s[i], i == 0);
    directed_count += s.len();
  endfunction

  // Mostly well-formed tokens, some with one byte corrupted, plus raw noise.
  function automatic void queue_random(input int count);
    int sent, r, n;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(9);
      if (r == 9) begin
        n = $urandom_range(1, 6);
        repeat (n) add_item(8'($urandom_range(255)), 1'($urandom_range(1)));
        sent += n;
      end else begin
        build_token(token_kind_t'($urandom_range(6)));
        if (r == 8) tok_q[$urandom_range(tok_q.size() - 1)] = 8'($urandom_range(255));
        foreach (tok_q[i]) add_item(tok_q[i], i == 0);
        sent += tok_q.size();
        token_count++;
      end
    end
    random_count += sent;
  endfunction

  task automatic wait_drained();
    do @(negedge clk); while (byte_q.size() != 0 || in_valid || result_q.size() != 0);
  endtask

  task automatic write_enable(input logic [ltnm_pkg::CFG_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    enable_model = v;
    setting_count++;
    @(negedge clk);
  endtask

  initial begin
    logic [ltnm_pkg::CFG_W-1:0] settings[5];
    settings[0] = 9'h000;
    settings[1] = 9'h1FF;
    settings[2] = 9'($urandom_range(511));
    settings[3] = 9'h001 << $urandom_range(8);
    settings[4] = 9'($urandom_range(511));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // The first byte after reset carries no restart flag.
    add_item("x", 1'b0);
    add_item(8'hFF, 1'b0);
    add_item(8'h00, 1'b1);
    add_item(8'h80, 1'b1);
    directed_count += 4;
    add_string(string'({"//a", CH_CR, CH_LF}));
    add_string("-12d");
    add_string(".5d");
    add_string("$fA");
    add_string("''''");
    add_string("#$f");

    foreach (settings[p]) begin
      wait_drained();
      repeat (4) @(posedge clk);
      write_enable(settings[p]);
      calm = (p == 3);
      queue_random(PHASE_ITEMS);
    end

    wait_drained();
    calm = 1'b0;
    repeat (10) @(posedge clk);
    $display("Checked %0d results: %0d directed bytes, %0d random bytes in %0d tokens",
             checked_count, directed_count, random_count, token_count);
    $display("Matcher enable was written %0d times, including all-off and all-on",
             setting_count);
    if (error_count == 0 && result_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
